@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the RTL that checks itself.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

@@ rtl/core/xmcrc_pkg.sv @@
package xmcrc_pkg;

  // Default payload length of one frame in bytes.
  localparam int PAYLOAD_BYTES_DEF = 128;

  // Control bytes of the protocol.
  localparam logic [7:0] BYTE_SOH = 8'h01;
  localparam logic [7:0] BYTE_EOT = 8'h04;

  // CRC-16 polynomial and its top bit.
  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [15:0] CRC_MSB  = 16'h8000;

  // Reset value of the first block number register.
  localparam logic [7:0] FIRST_BLOCK_RST = 8'h01;

  // Result kinds carried in tuser.
  typedef enum logic [1:0] {
    KIND_DATA    = 2'd0,
    KIND_VERDICT = 2'd1,
    KIND_END     = 2'd2
  } kind_t;

  // Reply codes: ACK means send 0x06, NAK means send 0x15.
  typedef enum logic [1:0] {
    REPLY_ACK  = 2'd0,
    REPLY_NAK  = 2'd1,
    REPLY_NONE = 2'd2
  } reply_t;

  // Fold one byte into the CRC, MSB first.
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if ((c & CRC_MSB) != 16'h0000) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

@@ rtl/core/xmodem_crc_receiver_core.sv @@
// XMODEM-CRC receiver core. Received serial bytes enter on the in_ stream, one per
// transaction, and the core can take one byte every clock cycle while the output
// side is not stalled. Each byte is captured in an input register, decoded against
// the frame state, and its result, if any, lands in an output register from which
// it is offered on the out_ stream. A byte that makes no result still waits for a
// free output register, so a held result stops the input after one more byte. Payload
// bytes come out at once as tentative data; the verdict after the CRC low byte tells
// downstream whether to commit them (packet_good) and which reply to send. A stray
// byte outside a frame is answered with NAK, EOT with an end-of-transfer result and
// ACK. The first_block_number register takes effect at the next EOT.
`include "assert_macros.svh"

module xmodem_crc_receiver_core #(
  parameter int PAYLOAD_BYTES = xmcrc_pkg::PAYLOAD_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // Configuration write of first_block_number.
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata,
  // Input stream. tdata: rx_byte[7:0].
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,
  // Result stream. tdata: payload_byte[7:0], byte_offset[14:8], reply_code[16:15],
  // packet_good[17], zero[23:18]. tuser: result_kind[1:0].
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,
  output logic [1:0]  out_tuser
);

  // Frame position counts bytes after SOH: 0 .. PAYLOAD_BYTES + 3.
  localparam int POS_W = $clog2(PAYLOAD_BYTES + 4);
  localparam logic [POS_W-1:0] POS_BLOCK  = POS_W'(0);
  localparam logic [POS_W-1:0] POS_CMPL   = POS_W'(1);
  localparam logic [POS_W-1:0] POS_DATA0  = POS_W'(2);
  localparam logic [POS_W-1:0] POS_CRC_HI = POS_W'(PAYLOAD_BYTES + 2);

  // Configuration register.
  logic [7:0] first_block_r;

  // Input register.
  logic       in_valid_r;
  logic [7:0] in_byte_r;

  // Frame state.
  logic             in_frame_r,     in_frame_nxt;
  logic [POS_W-1:0] frame_pos_r,    frame_pos_nxt;
  logic [15:0]      crc_r,          crc_nxt;
  logic [7:0]       rx_block_r,     rx_block_nxt;
  logic [7:0]       exp_block_r,    exp_block_nxt;
  logic [7:0]       crc_hi_r,       crc_hi_nxt;

  // Output register.
  logic              out_valid_r;
  xmcrc_pkg::kind_t  out_kind_r,  out_kind_nxt;
  logic [7:0]        out_data_r,  out_data_nxt;
  logic [6:0]        out_off_r,   out_off_nxt;
  xmcrc_pkg::reply_t out_reply_r, out_reply_nxt;
  logic              out_good_r,  out_good_nxt;
  logic              res_valid;

  logic             stage_adv;
  logic [POS_W-1:0] data_off;
  logic [POS_W+6:0] data_off_ext;
  logic [15:0]      crc_rx;

  // The decode stage moves on when the output register is free or being drained.
  assign stage_adv = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || stage_adv;

  assign data_off     = frame_pos_r - POS_DATA0;
  assign data_off_ext = {7'b0, data_off};
  assign crc_rx       = {crc_hi_r, in_byte_r};

  // Decode of the byte held in the input register.
  always_comb begin
    in_frame_nxt  = in_frame_r;
    frame_pos_nxt = frame_pos_r;
    crc_nxt       = crc_r;
    rx_block_nxt  = rx_block_r;
    exp_block_nxt = exp_block_r;
    crc_hi_nxt    = crc_hi_r;
    res_valid     = 1'b0;
    out_kind_nxt  = xmcrc_pkg::KIND_VERDICT;
    out_data_nxt  = 8'h00;
    out_off_nxt   = 7'd0;
    out_reply_nxt = xmcrc_pkg::REPLY_NONE;
    out_good_nxt  = 1'b0;
    if (!in_frame_r) begin
      if (in_byte_r == xmcrc_pkg::BYTE_SOH) begin
        in_frame_nxt  = 1'b1;
        frame_pos_nxt = POS_BLOCK;
        crc_nxt       = 16'h0000;
      end else if (in_byte_r == xmcrc_pkg::BYTE_EOT) begin
        exp_block_nxt = first_block_r;
        res_valid     = 1'b1;
        out_kind_nxt  = xmcrc_pkg::KIND_END;
        out_reply_nxt = xmcrc_pkg::REPLY_ACK;
      end else begin
        res_valid     = 1'b1;
        out_reply_nxt = xmcrc_pkg::REPLY_NAK;
      end
    end else begin
      frame_pos_nxt = frame_pos_r + POS_W'(1);
      if (frame_pos_r == POS_BLOCK) begin
        rx_block_nxt = in_byte_r;
      end else if (frame_pos_r == POS_CMPL) begin
        // The complement byte is skipped.
      end else if (frame_pos_r < POS_CRC_HI) begin
        crc_nxt      = xmcrc_pkg::crc_byte(crc_r, in_byte_r);
        res_valid    = 1'b1;
        out_kind_nxt = xmcrc_pkg::KIND_DATA;
        out_data_nxt = in_byte_r;
        out_off_nxt  = data_off_ext[6:0];
      end else if (frame_pos_r == POS_CRC_HI) begin
        crc_hi_nxt = in_byte_r;
      end else begin
        // CRC low byte closes the frame with a verdict.
        in_frame_nxt  = 1'b0;
        frame_pos_nxt = POS_BLOCK;
        crc_nxt       = 16'h0000;
        res_valid     = 1'b1;
        if (rx_block_r != exp_block_r) begin
          out_reply_nxt = xmcrc_pkg::REPLY_NONE;
        end else if (crc_rx == crc_r) begin
          exp_block_nxt = exp_block_r + 8'd1;
          out_reply_nxt = xmcrc_pkg::REPLY_ACK;
          out_good_nxt  = 1'b1;
        end else begin
          out_reply_nxt = xmcrc_pkg::REPLY_NAK;
        end
      end
    end
  end

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_block_r <= xmcrc_pkg::FIRST_BLOCK_RST;
    end else if (cfg_we) begin
      first_block_r <= cfg_wdata;
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
    if (in_tvalid && in_tready) begin
      in_byte_r <= in_tdata;
    end
  end

  // Frame state advances with each decoded byte.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r  <= 1'b0;
      frame_pos_r <= POS_BLOCK;
      crc_r       <= 16'h0000;
      rx_block_r  <= 8'h00;
      exp_block_r <= xmcrc_pkg::FIRST_BLOCK_RST;
      crc_hi_r    <= 8'h00;
    end else if (stage_adv) begin
      in_frame_r  <= in_frame_nxt;
      frame_pos_r <= frame_pos_nxt;
      crc_r       <= crc_nxt;
      rx_block_r  <= rx_block_nxt;
      exp_block_r <= exp_block_nxt;
      crc_hi_r    <= crc_hi_nxt;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (stage_adv) begin
      out_valid_r <= res_valid;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
    if (stage_adv && res_valid) begin
      out_kind_r  <= out_kind_nxt;
      out_data_r  <= out_data_nxt;
      out_off_r   <= out_off_nxt;
      out_reply_r <= out_reply_nxt;
      out_good_r  <= out_good_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tdata  = {6'b0, out_good_r, out_reply_r, out_off_r, out_data_r};

  // A nonzero frame position only exists inside a frame.
  `ASSERT_IMPLIES(a_pos_in_frame, clk, rst_n, frame_pos_r != POS_BLOCK, in_frame_r)
  // Payload results never carry a reply or a commit.
  `ASSERT_IMPLIES(a_data_no_reply, clk, rst_n,
    out_valid_r && out_kind_r == xmcrc_pkg::KIND_DATA,
    out_reply_r == xmcrc_pkg::REPLY_NONE && !out_good_r)
  // A commit is only an acknowledged verdict.
  `ASSERT_IMPLIES(a_good_is_ack, clk, rst_n, out_valid_r && out_good_r,
    out_kind_r == xmcrc_pkg::KIND_VERDICT && out_reply_r == xmcrc_pkg::REPLY_ACK)
  // A committed packet moves the expected block number on by one.
  `ASSERT_NEXT(a_block_advance, clk, rst_n, stage_adv && res_valid && out_good_nxt,
    exp_block_r == $past(exp_block_r) + 8'd1)

endmodule
